// ----- rtl/lsta_pkg.sv -----
// Package for the lazy segment tree block: sizes, tree node word and
// helper functions. No dependencies.
`default_nettype none
package lsta_pkg;

    localparam int LEAVES = 1024;
    localparam int LEVELS = $clog2(LEAVES);
    localparam int POS_W  = 11;
    localparam int IDX_W  = LEVELS;
    localparam int NODE_W = LEVELS + 1;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int DATA_W = 64;
    localparam int WORD_W = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] S64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S64_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] mx;
        logic signed [DATA_W-1:0] pend;
    } node_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] s;
        s = a + b;
        if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
        begin
            s = a[DATA_W-1] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // node at level lvl on the root path to leaf offset x
    function automatic logic [NODE_W-1:0] path_node(
        input logic [IDX_W-1:0] x,
        input logic [LVL_W-1:0] lvl
    );
        logic [NODE_W-1:0] top;
        top = NODE_W'(1) << lvl;
        return top | (NODE_W'(x) >> (LVL_W'(LEVELS) - lvl));
    endfunction

    // node at level lvl lies fully inside leaf offsets a..b
    function automatic logic covered(
        input logic [NODE_W-1:0] node,
        input logic [LVL_W-1:0]  lvl,
        input logic [IDX_W-1:0]  a,
        input logic [IDX_W-1:0]  b
    );
        logic [NODE_W-1:0] mask;
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
        mask = (NODE_W'(1) << lvl) - NODE_W'(1);
        lo   = (node & mask) << (LVL_W'(LEVELS) - lvl);
        hi   = lo | ((NODE_W'(1) << (LVL_W'(LEVELS) - lvl)) - NODE_W'(1));
        return (lo >= NODE_W'(a)) && (hi <= NODE_W'(b));
    endfunction

    // child word after a push of pend and an optional add of d
    function automatic node_t child_upd(
        input node_t                    c,
        input logic signed [DATA_W-1:0] pend,
        input logic                     add_en,
        input logic signed [DATA_W-1:0] d
    );
        node_t r;
        r.mx   = sat_add(c.mx, pend);
        r.pend = sat_add(c.pend, pend);
        if (add_en)
        begin
            r.mx   = sat_add(r.mx, d);
            r.pend = sat_add(r.pend, d);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lsta_if.sv -----
// Channel interfaces for the lazy segment tree block.
// Depends on lsta_pkg.
`default_nettype none
interface lsta_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [lsta_pkg::POS_W-1:0]          range_low;
    logic [lsta_pkg::POS_W-1:0]          range_high;
    logic signed [lsta_pkg::DATA_W-1:0]  delta;
    modport source (output valid, cmd, range_low, range_high, delta, input ready);
    modport sink   (input valid, cmd, range_low, range_high, delta, output ready);
endinterface

interface lsta_pos_if;
    logic                       valid;
    logic                       ready;
    logic [lsta_pkg::POS_W-1:0] position;
    modport source (output valid, position, input ready);
    modport sink   (input valid, position, output ready);
endinterface
`default_nettype wire

// ----- rtl/lsta_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module lsta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/lazy_segment_tree_add_max_core.sv -----
// Top level of the lazy segment tree (range add, leftmost positive find).
// Depends on lsta_pkg, lsta_cmd_if, lsta_pos_if and lsta_ram.
`default_nettype none
// One item at a time; all node words (max, pending) live in a single
// 2048 x 128 RAM with a registered read port, so the pace is set by
// its ports. After reset a clearing pass writes every entry before the
// first transfer. A find pushes the pending add of each path node into
// both children and steps left if the left max is positive, else right;
// at the leaf it waits for as long as an older result is still held in
// the output register. An add pushes pending adds on up to two boundary
// nodes per level on the way down and refreshes their maxima on the way
// up, skipping slots with nothing to do. A range that covers all leaves
// updates the root alone, and an empty range ends at once. A result
// waits in an output register while the next item is taken.
module lazy_segment_tree_add_max_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lsta_cmd_if.sink      req,
    lsta_pos_if.source    rsp
);

    typedef enum logic [12:0] {
        ST_CLEAR   = 13'b0000000000001,
        ST_IDLE    = 13'b0000000000010,
        ST_SEL     = 13'b0000000000100,
        ST_PUSH_RD = 13'b0000000001000,
        ST_PUSH_C0 = 13'b0000000010000,
        ST_PUSH_C1 = 13'b0000000100000,
        ST_PUSH_WB = 13'b0000001000000,
        ST_FIX_RD0 = 13'b0000010000000,
        ST_FIX_RD1 = 13'b0000100000000,
        ST_FIX_WR  = 13'b0001000000000,
        ST_ROOT_RD = 13'b0010000000000,
        ST_ROOT_WR = 13'b0100000000000,
        ST_HOLD    = 13'b1000000000000
    } state_t;

    localparam logic [lsta_pkg::NODE_W-1:0] ROOT = lsta_pkg::NODE_W'(1);
    localparam logic [lsta_pkg::LVL_W-1:0]  LAST_LVL =
        lsta_pkg::LVL_W'(lsta_pkg::LEVELS - 1);

    state_t                              state_reg, state_next;
    logic [lsta_pkg::NODE_W-1:0]         clr_reg, clr_next;
    logic [lsta_pkg::LVL_W-1:0]          lvl_reg, lvl_next;
    logic                                slot_reg, slot_next;
    logic                                up_reg, up_next;
    logic                                find_reg, find_next;
    logic                                dir_reg, dir_next;
    logic [lsta_pkg::NODE_W-1:0]         node_reg, node_next;
    logic [lsta_pkg::IDX_W-1:0]          a_reg, a_next;
    logic [lsta_pkg::IDX_W-1:0]          b_reg, b_next;
    logic signed [lsta_pkg::DATA_W-1:0]  delta_reg, delta_next;
    logic signed [lsta_pkg::DATA_W-1:0]  pend_reg, pend_next;
    logic signed [lsta_pkg::DATA_W-1:0]  cmax_reg, cmax_next;
    logic                                out_valid_reg, out_valid_next;
    logic [lsta_pkg::POS_W-1:0]          pos_reg, pos_next;

    logic                                ram_we;
    logic                                ram_re;
    logic [lsta_pkg::NODE_W-1:0]         ram_waddr;
    logic [lsta_pkg::NODE_W-1:0]         ram_raddr;
    lsta_pkg::node_t                     ram_wdata;
    logic [lsta_pkg::WORD_W-1:0]         ram_rword;
    lsta_pkg::node_t                     rd;

    logic [lsta_pkg::NODE_W-1:0]         child0, child1, cand;
    logic [lsta_pkg::NODE_W-1:0]         path_a, path_b;
    logic [lsta_pkg::LVL_W-1:0]          child_lvl;
    logic                                cand_ok;
    logic                                adv_done;
    logic [lsta_pkg::LVL_W-1:0]          adv_lvl;
    logic                                adv_slot, adv_up;
    lsta_pkg::node_t                     upd;
    logic                                add_c0, add_c1;
    logic [lsta_pkg::POS_W-1:0]          lo_eff, hi_eff;
    logic                                find_last;
    logic [lsta_pkg::POS_W-1:0]          leaf_pos;

    lsta_ram #(
        .WIDTH (lsta_pkg::WORD_W),
        .DEPTH (2 * lsta_pkg::LEAVES)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rword)
    );

    assign rd        = lsta_pkg::node_t'(ram_rword);
    assign child0    = {node_reg[lsta_pkg::NODE_W-2:0], 1'b0};
    assign child1    = {node_reg[lsta_pkg::NODE_W-2:0], 1'b1};
    assign child_lvl = lvl_reg + lsta_pkg::LVL_W'(1);
    assign path_a    = lsta_pkg::path_node(a_reg, lvl_reg);
    assign path_b    = lsta_pkg::path_node(b_reg, lvl_reg);
    assign cand      = slot_reg ? path_b : path_a;
    // boundary node still partly covered, and the B path not a repeat of A
    assign cand_ok   = !lsta_pkg::covered(cand, lvl_reg, a_reg, b_reg)
                       && !(slot_reg && path_a == path_b);
    assign add_c0    = !find_reg && lsta_pkg::covered(child0, child_lvl, a_reg, b_reg);
    assign add_c1    = !find_reg && lsta_pkg::covered(child1, child_lvl, a_reg, b_reg);
    assign find_last = (lvl_reg == LAST_LVL);
    assign leaf_pos  = lsta_pkg::POS_W'({child0[lsta_pkg::IDX_W-1:1], dir_reg})
                       + lsta_pkg::POS_W'(1);

    assign lo_eff = (req.range_low == '0) ? lsta_pkg::POS_W'(1) : req.range_low;
    assign hi_eff = (req.range_high > lsta_pkg::POS_W'(lsta_pkg::LEAVES))
                    ? lsta_pkg::POS_W'(lsta_pkg::LEAVES) : req.range_high;

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.position = pos_reg;

    // next boundary slot: A then B per level, down then up
    always_comb
    begin
        adv_done = 1'b0;
        adv_lvl  = lvl_reg;
        adv_slot = !slot_reg;
        adv_up   = up_reg;
        if (slot_reg)
        begin
            if (!up_reg)
            begin
                if (find_last)
                begin
                    adv_up = 1'b1;
                end
                else
                begin
                    adv_lvl = child_lvl;
                end
            end
            else if (lvl_reg == '0)
            begin
                adv_done = 1'b1;
            end
            else
            begin
                adv_lvl = lvl_reg - lsta_pkg::LVL_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        lvl_next       = lvl_reg;
        slot_next      = slot_reg;
        up_next        = up_reg;
        find_next      = find_reg;
        dir_next       = dir_reg;
        node_next      = node_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        delta_next     = delta_reg;
        pend_next      = pend_reg;
        cmax_next      = cmax_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        pos_next       = pos_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = node_reg;
        ram_raddr      = node_reg;
        ram_wdata      = '0;
        upd            = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + lsta_pkg::NODE_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    find_next  = req.cmd;
                    delta_next = req.delta;
                    a_next     = lsta_pkg::IDX_W'(lo_eff - lsta_pkg::POS_W'(1));
                    b_next     = lsta_pkg::IDX_W'(hi_eff - lsta_pkg::POS_W'(1));
                    lvl_next   = '0;
                    slot_next  = 1'b0;
                    up_next    = 1'b0;
                    node_next  = ROOT;
                    if (req.cmd)
                    begin
                        state_next = ST_PUSH_RD;
                    end
                    else if (lo_eff > hi_eff)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (lo_eff == lsta_pkg::POS_W'(1)
                             && hi_eff == lsta_pkg::POS_W'(lsta_pkg::LEAVES))
                    begin
                        state_next = ST_ROOT_RD;
                    end
                    else
                    begin
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                if (cand_ok)
                begin
                    node_next  = cand;
                    state_next = up_reg ? ST_FIX_RD0 : ST_PUSH_RD;
                end
                else
                begin
                    lvl_next   = adv_lvl;
                    slot_next  = adv_slot;
                    up_next    = adv_up;
                    state_next = adv_done ? ST_IDLE : ST_SEL;
                end
            end
            ST_PUSH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = node_reg;
                state_next = ST_PUSH_C0;
            end
            ST_PUSH_C0:
            begin
                ram_re         = 1'b1;
                ram_raddr      = child0;
                ram_we         = 1'b1;
                ram_waddr      = node_reg;
                ram_wdata.mx   = rd.mx;
                ram_wdata.pend = '0;
                pend_next      = rd.pend;
                state_next     = ST_PUSH_C1;
            end
            ST_PUSH_C1:
            begin
                ram_re     = 1'b1;
                ram_raddr  = child1;
                upd        = lsta_pkg::child_upd(rd, pend_reg, add_c0, delta_reg);
                ram_we     = 1'b1;
                ram_waddr  = child0;
                ram_wdata  = upd;
                dir_next   = !(!upd.mx[lsta_pkg::DATA_W-1] && upd.mx != '0);
                state_next = ST_PUSH_WB;
            end
            ST_PUSH_WB:
            begin
                upd       = lsta_pkg::child_upd(rd, pend_reg, add_c1, delta_reg);
                ram_we    = 1'b1;
                ram_waddr = child1;
                ram_wdata = upd;
                if (find_reg)
                begin
                    if (find_last)
                    begin
                        // leaf reached; wait in ST_HOLD while the last result is held
                        if (!out_valid_reg || rsp.ready)
                        begin
                            out_valid_next = 1'b1;
                            pos_next       = leaf_pos;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_HOLD;
                        end
                    end
                    else
                    begin
                        node_next  = {node_reg[lsta_pkg::NODE_W-2:0], dir_reg};
                        lvl_next   = child_lvl;
                        state_next = ST_PUSH_RD;
                    end
                end
                else
                begin
                    lvl_next   = adv_lvl;
                    slot_next  = adv_slot;
                    up_next    = adv_up;
                    state_next = ST_SEL;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = leaf_pos;
                    state_next     = ST_IDLE;
                end
            end
            ST_FIX_RD0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = child0;
                state_next = ST_FIX_RD1;
            end
            ST_FIX_RD1:
            begin
                ram_re     = 1'b1;
                ram_raddr  = child1;
                cmax_next  = rd.mx;
                state_next = ST_FIX_WR;
            end
            ST_FIX_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = node_reg;
                ram_wdata.mx   = (cmax_reg > rd.mx) ? cmax_reg : rd.mx;
                ram_wdata.pend = '0;
                lvl_next       = adv_lvl;
                slot_next      = adv_slot;
                up_next        = adv_up;
                state_next     = adv_done ? ST_IDLE : ST_SEL;
            end
            ST_ROOT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ROOT;
                state_next = ST_ROOT_WR;
            end
            ST_ROOT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ROOT;
                ram_wdata  = lsta_pkg::child_upd(rd, '0, 1'b1, delta_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lvl_reg       <= '0;
            slot_reg      <= 1'b0;
            up_reg        <= 1'b0;
            find_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lvl_reg       <= lvl_next;
            slot_reg      <= slot_next;
            up_reg        <= up_next;
            find_reg      <= find_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= dir_next;
        node_reg  <= node_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        delta_reg <= delta_next;
        pend_reg  <= pend_next;
        cmax_reg  <= cmax_next;
        pos_reg   <= pos_next;
    end

    // no transfer taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("input taken during clear");

    // read and write of one entry never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read/write collision on node RAM");

    // a finished find waits while an older result is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && out_valid_reg && !rsp.ready)
        |=> (state_reg == ST_HOLD))
        else $error("result overwritten");

    // a push never starts below the last inner level
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH_RD) |-> (lvl_reg <= LAST_LVL))
        else $error("push past inner levels");

endmodule
`default_nettype wire
